>>> rtl/wah_pkg.sv
// Package for the windowed amplitude histogram core.
// Holds field widths, configuration register indexes and state encodings.
// No dependencies.
`default_nettype none

package wah_pkg;

    // Fixed field widths.
    localparam int LEVEL_W   = 16;
    localparam int NBREG_W   = 7;
    localparam int CNT_W     = 16;
    localparam int BIN_NUM_W = 6;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEVEL   = 2'd0,
        CFG_MAX_LEVEL   = 2'd1,
        CFG_NUM_BINS    = 2'd2,
        CFG_WINDOW_SIZE = 2'd3
    } t_cfg_idx;

    // Main sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_FL_READ,
        ST_FL_LOAD
    } t_state;

    // Bin search unit states.
    typedef enum logic [1:0] {
        SR_IDLE,
        SR_MUL,
        SR_SCAN
    } t_srch_state;

endpackage

`default_nettype wire

>>> rtl/wah_if.sv
// Valid/ready channel interfaces for samples in and histogram beats out.
// Depends on wah_pkg for the result field widths.
`default_nettype none

interface wah_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_stream;

    modport source (output valid, sample, end_of_stream, input ready);
    modport sink   (input valid, sample, end_of_stream, output ready);
endinterface

interface wah_out_if
    import wah_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CNT_W-1:0]     window_number;
    logic [BIN_NUM_W-1:0] bin_number;
    logic [CNT_W-1:0]     bin_count;
    logic                 last_bin;

    modport source (output valid, window_number, bin_number, bin_count, last_bin,
                    input ready);
    modport sink   (input valid, window_number, bin_number, bin_count, last_bin,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/wah_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module wah_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/wah_bin_search.sv
// Bin search unit: one multiply, then a shared add and compare stepped over the bins.
// Depends on wah_pkg.
`default_nettype none

module wah_bin_search
    import wah_pkg::*;
#(
    parameter int MAX_BINS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_start,
    input  wire logic signed [SAMPLE_BITS-1:0]                 i_sample,
    input  wire logic signed [LEVEL_W-1:0]                     i_min_level,
    input  wire logic signed [LEVEL_W-1:0]                     i_max_level,
    input  wire logic [$clog2(MAX_BINS+1)-1:0]                 i_num_bins,
    output logic                                               o_done,
    output logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] o_bin
);

    localparam int NB_W   = $clog2(MAX_BINS + 1);
    localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int DIFF_W = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;
    localparam int SPAN_W = LEVEL_W + 1;
    localparam int LHS_W  = DIFF_W + NB_W + 1;

    t_srch_state              r_state, n_state;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [SPAN_W-1:0] r_span;
    logic signed [LHS_W-1:0]  r_lhs;
    logic signed [LHS_W-1:0]  r_acc;
    logic [BIN_W-1:0]         r_i;
    logic                     hit;

    // The scan stops at the first threshold that holds, or at the last bin in use.
    assign hit    = (r_lhs <= r_acc) || ((NB_W'(r_i) + NB_W'(1)) == i_num_bins);
    assign o_done = (r_state == SR_SCAN) && hit;
    assign o_bin  = r_i;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            SR_IDLE: begin
                if (i_start) begin
                    n_state = SR_MUL;
                end
            end
            SR_MUL: begin
                n_state = SR_SCAN;
            end
            SR_SCAN: begin
                if (hit) begin
                    n_state = SR_IDLE;
                end
            end
            default: begin
                n_state = SR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: offset and span, then nb*(sample-min), then (i+1)*span by repeated add.
    always_ff @(posedge i_clk) begin
        case (r_state)
            SR_IDLE: begin
                if (i_start) begin
                    r_diff <= DIFF_W'(i_sample) - DIFF_W'(i_min_level);
                    r_span <= SPAN_W'(i_max_level) - SPAN_W'(i_min_level);
                end
            end
            SR_MUL: begin
                r_lhs <= LHS_W'(r_diff) * LHS_W'($signed({1'b0, i_num_bins}));
                r_acc <= LHS_W'(r_span);
                r_i   <= '0;
            end
            SR_SCAN: begin
                if (!hit) begin
                    r_acc <= r_acc + LHS_W'(r_span);
                    r_i   <= r_i + BIN_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/windowed_amplitude_histogram_core.sv
// Windowed amplitude histogram core. After a sample is accepted the input is held not
// ready until its counter update and any window flush it starts are done; the bin search
// unit finds its bin (0..num_bins-1), stepping one threshold per cycle after one multiply.
// A window flush takes a counter RAM read and an output load for each bin in use, and the
// output load waits while the output side stalls.
// Reset is synchronous and active low; it restores the register defaults and clears all
// bin counters at once through per-bin valid bits.
`default_nettype none

module windowed_amplitude_histogram_core
    import wah_pkg::*;
#(
    parameter int MAX_BINS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    wah_in_if.sink                    i_samp,
    wah_out_if.source                 o_hist
);

    localparam int NB_W  = $clog2(MAX_BINS + 1);
    localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CMP_W = (NB_W > NBREG_W) ? NB_W : NBREG_W;

    // Configuration registers.
    logic signed [LEVEL_W-1:0] r_min_level;
    logic signed [LEVEL_W-1:0] r_max_level;
    logic [NBREG_W-1:0]        r_num_bins;
    logic [CNT_W-1:0]          r_window_size;

    // Sequencer and window state.
    t_state                r_state, n_state;
    logic [MAX_BINS-1:0]   r_valid;
    logic [CNT_W-1:0]      r_siw;
    logic [CNT_W-1:0]      r_win;
    logic                  r_eos;
    logic [BIN_W-1:0]      r_bin;
    logic [BIN_W-1:0]      r_idx;

    // Output register.
    logic                  r_ov;
    logic [CNT_W-1:0]      r_o_win;
    logic [BIN_NUM_W-1:0]  r_o_bin;
    logic [CNT_W-1:0]      r_o_cnt;
    logic                  r_o_last;

    logic [NB_W-1:0]       eff_nb;
    logic [CNT_W-1:0]      eff_ws;
    logic                  accept;
    logic                  srch_done;
    logic [BIN_W-1:0]      srch_bin;
    logic                  ram_we;
    logic [BIN_W-1:0]      ram_raddr;
    logic [CNT_W-1:0]      ram_rdata;
    logic [CNT_W-1:0]      cur_cnt;
    logic [CNT_W-1:0]      upd_cnt;
    logic [CNT_W-1:0]      siw_inc;
    logic                  flush_now;
    logic [CNT_W-1:0]      fl_cnt;
    logic                  fl_last;
    logic                  out_free;
    logic                  out_load;
    logic                  fl_done;

    // Effective bin count and window size.
    always_comb begin
        if (r_num_bins == '0) begin
            eff_nb = NB_W'(1);
        end else if (CMP_W'(r_num_bins) > CMP_W'(MAX_BINS)) begin
            eff_nb = NB_W'(MAX_BINS);
        end else begin
            eff_nb = NB_W'(CMP_W'(r_num_bins));
        end
    end

    assign eff_ws = (r_window_size == '0) ? CNT_W'(1) : r_window_size;

    assign i_samp.ready = (r_state == ST_IDLE);
    assign accept       = i_samp.valid && i_samp.ready;

    wah_bin_search #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_sample    (i_samp.sample),
        .i_min_level (r_min_level),
        .i_max_level (r_max_level),
        .i_num_bins  (eff_nb),
        .o_done      (srch_done),
        .o_bin       (srch_bin)
    );

    assign ram_raddr = (r_state == ST_SEARCH) ? srch_bin : r_idx;

    wah_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BINS)
    ) u_counters (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bin),
        .i_wdata (upd_cnt),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Counter update with saturation; an entry not written since the last clear reads as zero.
    assign cur_cnt   = r_valid[r_bin] ? ram_rdata : '0;
    assign upd_cnt   = (cur_cnt == '1) ? cur_cnt : cur_cnt + CNT_W'(1);
    assign siw_inc   = (r_siw == '1) ? r_siw : r_siw + CNT_W'(1);
    assign flush_now = r_eos || (siw_inc >= eff_ws);

    // Flush read-out.
    assign fl_cnt   = r_valid[r_idx] ? ram_rdata : '0;
    assign fl_last  = (NB_W'(r_idx) + NB_W'(1)) == eff_nb;
    assign out_free = !r_ov || o_hist.ready;

    // Next state and strobes.
    always_comb begin
        n_state  = r_state;
        ram_we   = 1'b0;
        out_load = 1'b0;
        fl_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (srch_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                ram_we  = 1'b1;
                n_state = flush_now ? ST_FL_READ : ST_IDLE;
            end
            ST_FL_READ: begin
                n_state = ST_FL_LOAD;
            end
            ST_FL_LOAD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (fl_last) begin
                        fl_done = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_FL_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_min_level   <= -16'sd32768;
            r_max_level   <= 16'sd32767;
            r_num_bins    <= NBREG_W'(16);
            r_window_size <= CNT_W'(1024);
            r_valid       <= '0;
            r_siw         <= '0;
            r_win         <= '0;
            r_ov          <= 1'b0;
            r_idx         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MIN_LEVEL:   r_min_level   <= i_cfg_data;
                    CFG_MAX_LEVEL:   r_max_level   <= i_cfg_data;
                    CFG_NUM_BINS:    r_num_bins    <= i_cfg_data[NBREG_W-1:0];
                    CFG_WINDOW_SIZE: r_window_size <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (ram_we) begin
                r_valid[r_bin] <= 1'b1;
                r_siw          <= siw_inc;
                r_idx          <= '0;
            end
            if (out_load) begin
                r_idx <= r_idx + BIN_W'(1);
            end
            if (fl_done) begin
                r_valid <= '0;
                r_siw   <= '0;
                r_win   <= r_eos ? '0 : r_win + CNT_W'(1);
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_hist.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Item and output payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_eos <= i_samp.end_of_stream;
        end
        if ((r_state == ST_SEARCH) && srch_done) begin
            r_bin <= srch_bin;
        end
        if (out_load) begin
            r_o_win  <= r_win;
            r_o_bin  <= BIN_NUM_W'(r_idx);
            r_o_cnt  <= fl_cnt;
            r_o_last <= fl_last;
        end
    end

    assign o_hist.valid         = r_ov;
    assign o_hist.window_number = r_o_win;
    assign o_hist.bin_number    = r_o_bin;
    assign o_hist.bin_count     = r_o_cnt;
    assign o_hist.last_bin      = r_o_last;

    // The search never reports a bin outside the bins in use.
    a_bin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_done |-> (NB_W'(srch_bin) < eff_nb))
        else $error("bin search result beyond the bins in use");

    // A counter update leaves at least one bin marked as written.
    a_update_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=> (r_valid != '0))
        else $error("counter update did not mark its bin");

    // A completed flush clears every counter.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fl_done |=> (r_valid == '0) && (r_siw == '0))
        else $error("window flush left counters uncleared");

endmodule

`default_nettype wire
